/* rtl/binary_trie_prefix_matcher_macros.svh */
// Assertion macros for the binary trie prefix matcher.
`ifndef BINARY_TRIE_PREFIX_MATCHER_MACROS_SVH
`define BINARY_TRIE_PREFIX_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define BTPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btpm assertion failed");
// Next-cycle implication under an active-low reset.
`define BTPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpm assertion failed");
`else
`define BTPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BTPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/btpm_pkg.sv */
// Package: shared constants, status codes and step control type.
`timescale 1ns / 1ps
package btpm_pkg;

  localparam int ADDR_BITS_DEF  = 32;
  localparam int NODE_COUNT_DEF = 1024;

  localparam int ADDR_FIELD_W = 32;
  localparam int COUNT_W      = 6;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_NO_MATCH    = 2'd0,
    ST_MATCH       = 2'd1,
    ST_INSERT_DONE = 2'd2,
    ST_POOL_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic    finish;
    logic    advance;
    logic    alloc;
    logic    write;
    status_e status;
  } step_ctl_t;

endpackage

/* rtl/btpm_in_if.sv */
// Interface: request channel carrying one insert or lookup.
`timescale 1ns / 1ps
interface btpm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [btpm_pkg::ADDR_FIELD_W-1:0]    address_bits;
  logic [btpm_pkg::COUNT_W-1:0]         bit_count;
  logic                                 is_prefix;

  modport source (output valid, action, address_bits, bit_count, is_prefix, input ready);
  modport sink   (input valid, action, address_bits, bit_count, is_prefix, output ready);
endinterface

/* rtl/btpm_out_if.sv */
// Interface: response channel carrying one status.
`timescale 1ns / 1ps
interface btpm_out_if;
  logic              valid;
  logic              ready;
  btpm_pkg::status_e status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

/* rtl/btpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module btpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/btpm_step.sv */
// Step unit: decides one trie walk step from the current node and bit.
`timescale 1ns / 1ps
module btpm_step #(
  parameter int NODE_COUNT = btpm_pkg::NODE_COUNT_DEF
) (
  input  logic [2*$clog2(NODE_COUNT)+1:0] node_i,
  input  logic                            lookup_i,
  input  logic                            wild_i,
  input  logic                            stepped_i,
  input  logic                            last_i,
  input  logic                            bit_i,
  input  logic                            pool_full_i,
  input  logic [$clog2(NODE_COUNT)-1:0]   new_idx_i,
  output btpm_pkg::step_ctl_t             ctl_o,
  output logic [$clog2(NODE_COUNT)-1:0]   child_o,
  output logic [2*$clog2(NODE_COUNT)+1:0] wnode_o
);

  localparam int IW = $clog2(NODE_COUNT);

  logic                 end_mark;
  logic                 prefix_mark;
  logic [IW-1:0]        child0;
  logic [IW-1:0]        child1;

  assign end_mark    = node_i[0];
  assign prefix_mark = node_i[1];
  assign child0      = node_i[IW+1 -: IW];
  assign child1      = node_i[2*IW+1 -: IW];
  assign child_o     = bit_i ? child1 : child0;

  always_comb begin
    ctl_o        = '0;
    ctl_o.status = btpm_pkg::ST_NO_MATCH;
    wnode_o      = node_i;
    if (lookup_i) begin
      if (last_i) begin
        ctl_o.finish = 1'b1;
        ctl_o.status = (end_mark || prefix_mark) ? btpm_pkg::ST_MATCH
                                                 : btpm_pkg::ST_NO_MATCH;
      end else if (prefix_mark) begin
        ctl_o.finish = 1'b1;
        ctl_o.status = btpm_pkg::ST_MATCH;
      end else if (child_o == '0) begin
        ctl_o.finish = 1'b1;
      end else begin
        ctl_o.advance = 1'b1;
      end
    end else begin
      if (last_i || (stepped_i && prefix_mark)) begin
        // mark the node where the walk stops
        ctl_o.finish = 1'b1;
        ctl_o.write  = 1'b1;
        ctl_o.status = btpm_pkg::ST_INSERT_DONE;
        wnode_o[0]   = 1'b1;
        wnode_o[1]   = prefix_mark | wild_i;
      end else if (child_o != '0) begin
        ctl_o.advance = 1'b1;
      end else if (pool_full_i) begin
        ctl_o.finish = 1'b1;
        ctl_o.status = btpm_pkg::ST_POOL_FULL;
      end else begin
        // link a fresh node into the parent
        ctl_o.alloc = 1'b1;
        ctl_o.write = 1'b1;
        if (bit_i) begin
          wnode_o[2*IW+1 -: IW] = new_idx_i;
        end else begin
          wnode_o[IW+1 -: IW] = new_idx_i;
        end
      end
    end
  end

endmodule

/* rtl/binary_trie_prefix_matcher.sv */
// Top level: binary trie prefix matcher with a sequenced walk over a node RAM.
//
//   Channel | Dir | Handshake    | Payload
//   in_i    | in  | valid/ready  | action, address_bits, bit_count, is_prefix
//   out_o   | out | valid/ready  | status
//
// Walk: an item of n walked bits (n clamped to ADDR_BITS) reads one node per level from
//   acceptance to a valid response; an insert also passes through S_ALLOC for each node it
//   allocates, and an early stop on a prefix or missing child is shorter.
// Reset: asynchronous, active low; the S_INIT state after reset clears the root node.
// Stalls: one transaction at a time; in_i.ready is low from acceptance until the
//   response transaction on out_o completes.
`timescale 1ns / 1ps
`include "binary_trie_prefix_matcher_macros.svh"
module binary_trie_prefix_matcher #(
  parameter int ADDR_BITS  = btpm_pkg::ADDR_BITS_DEF,
  parameter int NODE_COUNT = btpm_pkg::NODE_COUNT_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  btpm_in_if.sink     in_i,
  btpm_out_if.source  out_o
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int UW = $clog2(NODE_COUNT + 1);
  localparam int NW = 2 * IW + 2;
  localparam int CW = $clog2(ADDR_BITS + 1);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_ALLOC = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_BITS-1:0] bits_q, bits_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [IW-1:0]       cur_q, cur_d;
  logic [UW-1:0]       used_q, used_d;
  logic                lookup_q, lookup_d;
  logic                wild_q, wild_d;
  logic                stepped_q, stepped_d;
  logic                fresh_q, fresh_d;
  btpm_pkg::status_e   status_q, status_d;

  // request decode
  logic [6:0]           cnt_full;
  logic [CW-1:0]        cnt_clamp;
  logic [ADDR_BITS-1:0] bits_aligned;

  // RAM port
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [NW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [NW-1:0] ram_rdata;

  // step unit
  logic [NW-1:0]       node_cur;
  btpm_pkg::step_ctl_t ctl;
  logic [IW-1:0]       child;
  logic [NW-1:0]       wnode;
  logic                pool_full;

  // Clamp the bit count to the trie depth and left-align the rule so that
  // the first bit walked sits at the top of the shift register.
  assign cnt_full     = ({1'b0, in_i.bit_count} > 7'(ADDR_BITS)) ? 7'(ADDR_BITS)
                                                                 : {1'b0, in_i.bit_count};
  assign cnt_clamp    = CW'(cnt_full);
  assign bits_aligned = ADDR_BITS'(in_i.address_bits) << (CW'(ADDR_BITS) - cnt_clamp);

  assign pool_full = (used_q == UW'(NODE_COUNT));
  // a freshly allocated node is known to be all zero, so skip its read
  assign node_cur  = fresh_q ? '0 : ram_rdata;

  btpm_ram #(
    .WIDTH (NW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  btpm_step #(
    .NODE_COUNT (NODE_COUNT)
  ) u_step (
    .node_i      (node_cur),
    .lookup_i    (lookup_q),
    .wild_i      (wild_q),
    .stepped_i   (stepped_q),
    .last_i      (cnt_q == '0),
    .bit_i       (bits_q[ADDR_BITS-1]),
    .pool_full_i (pool_full),
    .new_idx_i   (IW'(used_q)),
    .ctl_o       (ctl),
    .child_o     (child),
    .wnode_o     (wnode)
  );

  // RAM control: clear the root after reset, write back marks or a new
  // child link while evaluating, zero a newly allocated node.
  assign ram_we    = (state_q == S_INIT) || (state_q == S_ALLOC) ||
                     ((state_q == S_EVAL) && ctl.write);
  assign ram_waddr = (state_q == S_INIT) ? '0 : cur_q;
  assign ram_wdata = (state_q == S_EVAL) ? wnode : '0;
  // Fetch the child in the same cycle as the decision to descend.
  assign ram_re    = (state_q == S_READ) || ((state_q == S_EVAL) && ctl.advance);
  assign ram_raddr = (state_q == S_READ) ? cur_q : child;

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = (state_q == S_DONE);
  assign out_o.status = status_q;

  always_comb begin
    state_d   = state_q;
    bits_d    = bits_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    used_d    = used_q;
    lookup_d  = lookup_q;
    wild_d    = wild_q;
    stepped_d = stepped_q;
    fresh_d   = fresh_q;
    status_d  = status_q;
    unique case (state_q)
      S_INIT: begin
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_i.valid) begin
          bits_d    = bits_aligned;
          cnt_d     = cnt_clamp;
          cur_d     = '0;
          lookup_d  = (in_i.action == btpm_pkg::ACT_LOOKUP);
          wild_d    = in_i.is_prefix;
          stepped_d = 1'b0;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        fresh_d = 1'b0;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (ctl.finish) begin
          status_d = ctl.status;
          state_d  = S_DONE;
        end else if (ctl.advance) begin
          // descend: child read is already in flight
          cur_d     = child;
          cnt_d     = cnt_q - CW'(1);
          bits_d    = bits_q << 1;
          stepped_d = 1'b1;
          fresh_d   = 1'b0;
        end else if (ctl.alloc) begin
          // take the next free node and zero it in the following cycle
          cur_d     = IW'(used_q);
          used_d    = used_q + UW'(1);
          cnt_d     = cnt_q - CW'(1);
          bits_d    = bits_q << 1;
          stepped_d = 1'b1;
          fresh_d   = 1'b1;
          state_d   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        state_d = S_EVAL;
      end
      S_DONE: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      used_q    <= UW'(1);
      stepped_q <= 1'b0;
      fresh_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      stepped_q <= stepped_d;
      fresh_q   <= fresh_d;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    bits_q   <= bits_d;
    cnt_q    <= cnt_d;
    cur_q    <= cur_d;
    lookup_q <= lookup_d;
    wild_q   <= wild_d;
    status_q <= status_d;
  end

  // Node count never runs past the pool.
  `BTPM_ASSERT_NOW(a_used_bounded, clk_i, rst_ni, 1'b1, used_q <= UW'(NODE_COUNT))
  // Request and response sides are never open together.
  `BTPM_ASSERT_NOW(a_one_in_flight, clk_i, rst_ni, in_i.ready, !out_o.valid)
  // Every allocation takes exactly one node.
  `BTPM_ASSERT_NEXT(a_alloc_count, clk_i, rst_ni, (state_q == S_EVAL) && ctl.alloc,
                    used_q == $past(used_q) + UW'(1))
  // Pool-full is only reported once the pool really is exhausted.
  `BTPM_ASSERT_NOW(a_full_report, clk_i, rst_ni,
                   out_o.valid && (out_o.status == btpm_pkg::ST_POOL_FULL),
                   used_q == UW'(NODE_COUNT))

endmodule

/* sim/btpm_tb_checker.sv */
// Checker: shadow trie that predicts each response status and compares it with the block.
`timescale 1ns / 1ps
module btpm_tb_checker (
  input  logic clk_i,
  input  logic rst_ni,
  btpm_in_if   req_i,
  btpm_out_if  rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   no_match_o,
  output int   match_o,
  output int   stored_o,
  output int   refused_o
);

  localparam int DEPTH      = btpm_pkg::NODE_COUNT_DEF;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int WALK_MAX   = btpm_pkg::ADDR_BITS_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] zero_link;
    logic [IDX_W-1:0] one_link;
    logic             wild_mark;
    logic             end_mark;
  } trie_node_t;

  trie_node_t          shadow_trie [DEPTH];
  int unsigned         nodes_taken;
  btpm_pkg::status_e   expected_status_q [$];
  btpm_pkg::status_e   want;

  // Walk the shadow trie for one transaction; inserts update it as the block should.
  function automatic btpm_pkg::status_e predict_status(
      logic act, logic [btpm_pkg::ADDR_FIELD_W-1:0] bits,
      logic [btpm_pkg::COUNT_W-1:0] cnt, logic wild);
    int unsigned depth;
    int unsigned cur;
    int unsigned nxt;
    logic        b;
    depth = (cnt > WALK_MAX) ? WALK_MAX : cnt;
    cur   = 0;
    if (act == btpm_pkg::ACT_INSERT) begin
      for (int i = depth; i > 0; i--) begin
        b   = bits[i-1];
        nxt = b ? shadow_trie[cur].one_link : shadow_trie[cur].zero_link;
        if (nxt == 0) begin
          // Pool exhausted: nodes already taken by this insert stay unmarked.
          if (nodes_taken >= DEPTH) return btpm_pkg::ST_POOL_FULL;
          nxt = nodes_taken;
          nodes_taken++;
          shadow_trie[nxt] = '0;
          if (b) shadow_trie[cur].one_link = IDX_W'(nxt);
          else   shadow_trie[cur].zero_link = IDX_W'(nxt);
        end
        cur = nxt;
        if (shadow_trie[cur].wild_mark) break;
      end
      if (wild) shadow_trie[cur].wild_mark = 1'b1;
      shadow_trie[cur].end_mark = 1'b1;
      return btpm_pkg::ST_INSERT_DONE;
    end
    for (int i = depth; i > 0; i--) begin
      if (shadow_trie[cur].wild_mark) return btpm_pkg::ST_MATCH;
      nxt = bits[i-1] ? shadow_trie[cur].one_link : shadow_trie[cur].zero_link;
      if (nxt == 0) return btpm_pkg::ST_NO_MATCH;
      cur = nxt;
    end
    return (shadow_trie[cur].end_mark || shadow_trie[cur].wild_mark) ? btpm_pkg::ST_MATCH
                                                                      : btpm_pkg::ST_NO_MATCH;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) shadow_trie[k] = '0;
      nodes_taken = 1;
      expected_status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      no_match_o   = 0;
      match_o      = 0;
      stored_o     = 0;
      refused_o    = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        expected_status_q.push_back(predict_status(req_i.action, req_i.address_bits,
                                                   req_i.bit_count, req_i.is_prefix));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_status_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: status expected none, actual %0d", $time, rsp_i.status);
        end else begin
          want = expected_status_q.pop_front();
          if (rsp_i.status !== want) begin
            fail_count_o++;
            $display("%0t: status expected %0d, actual %0d", $time, want, rsp_i.status);
          end
          case (want)
            btpm_pkg::ST_NO_MATCH:    no_match_o++;
            btpm_pkg::ST_MATCH:       match_o++;
            btpm_pkg::ST_INSERT_DONE: stored_o++;
            default:                  refused_o++;
          endcase
        end
      end
      pending_o = expected_status_q.size();
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench top: request and response stimulus around the trie matcher, and the verdict.
`timescale 1ns / 1ps
module tb_top;

  // Random part length, the calm stretch, the point of the long response hold-off and its length, the rule store size.
  localparam int RANDOM_ITEMS = 930;
  localparam int CALM_FROM    = 300;
  localparam int CALM_TO      = 450;
  localparam int HOLD_AFTER   = 500;
  localparam int LONG_HOLD    = 300;
  localparam int RULE_KEEP    = 64;
  // Longest walk reads every level and allocates a node at each before its result; leave margin.
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic                              action;
    logic [btpm_pkg::ADDR_FIELD_W-1:0] bits;
    logic [btpm_pkg::COUNT_W-1:0]      count;
    logic                              wild;
  } request_t;

  logic clk_i;
  logic rst_ni;
  logic quiet = 1'b0;

  int fail_count;
  int pending;
  int n_no_match;
  int n_match;
  int n_stored;
  int n_refused;

  // Up to RULE_KEEP rules handed to the block, so that lookups can aim at real paths.
  logic [btpm_pkg::ADDR_FIELD_W-1:0] rule_bits_q [$];
  int                                rule_len_q  [$];

  btpm_in_if  req_ch ();
  btpm_out_if rsp_ch ();

  binary_trie_prefix_matcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  btpm_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .no_match_o   (n_no_match),
    .match_o      (n_match),
    .stored_o     (n_stored),
    .refused_o    (n_refused)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic request_t req(logic act, logic [btpm_pkg::ADDR_FIELD_W-1:0] bits,
                                   int cnt, logic wild);
    request_t r;
    r.action = act;
    r.bits   = bits;
    r.count  = btpm_pkg::COUNT_W'(cnt);
    r.wild   = wild;
    return r;
  endfunction

  // Mostly short rules so that the node pool lasts; some of medium length, some full length or beyond it.
  function automatic int pick_span();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(12);
    if (sel < 90) return $urandom_range(31, 13);
    return $urandom_range(63, 32);
  endfunction

  // Offer one transaction: idle first at random outside the calm stretch, then hold valid until it is taken.
  task automatic offer(input request_t r);
    while (!quiet && $urandom_range(99) < 28) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= r.action;
    req_ch.address_bits <= r.bits;
    req_ch.bit_count    <= r.count;
    req_ch.is_prefix    <= r.wild;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold until every outstanding response has come back.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // Response side: random back-pressure, none during the calm stretch, and one long
  // hold-off once enough responses have passed, counted here cycle by cycle.
  initial begin : response_sink
    int   hold_left;
    logic hold_spent;
    hold_left  = 0;
    hold_spent = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_spent && (n_no_match + n_match + n_stored + n_refused) >= HOLD_AFTER) begin
        hold_spent = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin : request_source
    request_t                          r;
    int                                n;
    int                                pick;
    int                                span;
    int                                ext;
    logic [btpm_pkg::ADDR_FIELD_W-1:0] rb;
    logic [btpm_pkg::ADDR_FIELD_W-1:0] field_mask;

    rst_ni              <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= btpm_pkg::ACT_INSERT;
    req_ch.address_bits <= '0;
    req_ch.bit_count    <= '0;
    req_ch.is_prefix    <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty trie, root marks, extreme patterns, wildcard cut-off,
    // clamped bit count, missing children and lookups carrying the prefix flag.
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h0000_0000, 0, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'h0000_0000, 0, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 0, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 31, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'h0000_0000, 32, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h0000_0000, 63, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'h0000_000A, 4, 1'b1));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'hAFFF_FFFF, 32, 1'b1));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'hFFFF_FFFA, 4, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'h0000_00A5, 8, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h0000_00A5, 8, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'h1234_5678, 40, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h1234_5678, 32, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h1234_5679, 32, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h5000_0000, 32, 1'b0));
    offer(req(btpm_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, 32'h0000_0001, 1, 1'b1));

    // Random part: inserts build the trie until the pool runs dry; most lookups
    // follow stored rules, some extended past them, the rest are noise.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_FROM) begin
        drain_responses();
        quiet = 1'b1;
      end
      if (n == CALM_TO) quiet = 1'b0;

      if ($urandom_range(99) < 40) begin
        if (rule_len_q.size() > 0 && $urandom_range(99) < 35) begin
          pick = $urandom_range(rule_len_q.size() - 1);
          r    = req(btpm_pkg::ACT_INSERT, rule_bits_q[pick], rule_len_q[pick], 1'b0);
        end else begin
          span = pick_span();
          r    = req(btpm_pkg::ACT_INSERT, $urandom, span, 1'b0);
          if (span > btpm_pkg::ADDR_BITS_DEF) span = btpm_pkg::ADDR_BITS_DEF;
          if (rule_len_q.size() < RULE_KEEP) begin
            rule_bits_q.push_back(r.bits);
            rule_len_q.push_back(span);
          end else begin
            pick              = $urandom_range(RULE_KEEP - 1);
            rule_bits_q[pick] = r.bits;
            rule_len_q[pick]  = span;
          end
        end
        // Keep wildcards off short rules, and off the root until the very end.
        r.wild = (r.count >= 6) && ($urandom_range(3) == 0);
      end else if (rule_len_q.size() > 0 && $urandom_range(99) < 65) begin
        pick       = $urandom_range(rule_len_q.size() - 1);
        rb         = rule_bits_q[pick];
        span       = rule_len_q[pick];
        ext        = $urandom_range(btpm_pkg::ADDR_BITS_DEF - span);
        field_mask = (span == 0) ? '0 : ((32'hFFFF_FFFF >> (32 - span)) << ext);
        r          = req(btpm_pkg::ACT_LOOKUP,
                         ($urandom & ~field_mask) | ((rb << ext) & field_mask),
                         span + ext, 1'($urandom_range(1)));
        if (span + ext == btpm_pkg::ADDR_BITS_DEF && $urandom_range(3) == 0)
          r.count = btpm_pkg::COUNT_W'($urandom_range(63, 33));
      end else begin
        r = req(btpm_pkg::ACT_LOOKUP, $urandom, pick_span(), 1'($urandom_range(1)));
      end
      offer(r);
    end

    // Wildcard on the root swallows every later lookup, so leave it for the tail.
    offer(req(btpm_pkg::ACT_INSERT, $urandom, 0, 1'b1));
    offer(req(btpm_pkg::ACT_LOOKUP, $urandom, 5, 1'b0));
    offer(req(btpm_pkg::ACT_LOOKUP, $urandom, 32, 1'b1));
    offer(req(btpm_pkg::ACT_LOOKUP, $urandom, 0, 1'b0));

    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb_top: inserts %0d stored, %0d refused on a full node pool",
             n_stored, n_refused);
    $display("tb_top: lookups %0d matched, %0d missed", n_match, n_no_match);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
